### design/ttb_pkg.sv
package ttb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W = 24;
	localparam int TEX_W = 20;
	localparam int OUT_W = 32;
	localparam int EDGE_W = POS_W + 1;
	localparam int DUV_W = TEX_W + 1;
	// det and numerators, signed
	localparam int DET_W = 2 * DUV_W + 1;
	localparam int NUM_W = EDGE_W + DUV_W + 1;
	// magnitudes
	localparam int NMAG_W = NUM_W;
	localparam int DMAG_W = DET_W;
	// dividend after scaling by 2^FRAC_BITS
	localparam int DIVD_W = NMAG_W + FRAC_BITS;
	localparam int DCNT_W = $clog2(DIVD_W + 1);

	// datapath operation codes
	typedef enum logic [2:0] {
		OP_NONE,
		OP_STORE,
		OP_DELTA,
		OP_DET,
		OP_NUM,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_DIV_SAVE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       slot;   // which stored corner
		logic [2:0] sel;    // numerator index 0..5
	} cmd_t;

	typedef struct packed {
		logic det_zero;
		logic div_done;
	} sts_t;

endpackage

### design/ttb_ctrl.sv
module ttb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output ttb_pkg::cmd_t   cmd,
	input  ttb_pkg::sts_t   sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DET,
		S_NUM,
		S_DSTART,
		S_DSTEP,
		S_SAVE,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] count_q;
	logic [2:0] sel_q;

	assign in_ready  = (state_q == S_IDLE) && !out_valid;

	// drive datapath commands
	always_comb begin
		cmd.op   = ttb_pkg::OP_NONE;
		cmd.slot = count_q[0];
		cmd.sel  = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = (count_q == 2'd2) ? ttb_pkg::OP_DELTA : ttb_pkg::OP_STORE;
				end
			end
			S_DET:    cmd.op = ttb_pkg::OP_DET;
			S_NUM:    cmd.op = ttb_pkg::OP_NUM;
			S_DSTART: cmd.op = ttb_pkg::OP_DIV_START;
			S_DSTEP:  cmd.op = ttb_pkg::OP_DIV_STEP;
			S_SAVE:   cmd.op = ttb_pkg::OP_DIV_SAVE;
			S_OUT:    cmd.op = ttb_pkg::OP_NONE;
			default:  cmd.op = ttb_pkg::OP_NONE;
		endcase
	end

	// sequence one triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= 2'd0;
			sel_q     <= 3'd0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (count_q == 2'd2) begin
							count_q <= 2'd0;
							state_q <= S_DET;
						end else begin
							count_q <= count_q + 2'd1;
						end
					end
				end
				S_DET: begin
					sel_q   <= 3'd0;
					state_q <= S_NUM;
				end
				S_NUM: begin
					state_q <= sts.det_zero ? S_OUT : S_DSTART;
				end
				S_DSTART: state_q <= S_DSTEP;
				S_DSTEP: begin
					if (sts.div_done) state_q <= S_SAVE;
				end
				S_SAVE: begin
					if (sel_q == 3'd5) begin
						state_q <= S_OUT;
					end else begin
						sel_q   <= sel_q + 3'd1;
						state_q <= S_DSTART;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/ttb_dpath.sv
module ttb_dpath (
	input  logic                                clk,
	input  ttb_pkg::cmd_t                       cmd,
	output ttb_pkg::sts_t                       sts,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_x,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_y,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_z,
	input  logic signed [ttb_pkg::TEX_W-1:0]    tex_u,
	input  logic signed [ttb_pkg::TEX_W-1:0]    tex_v,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_x,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_y,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_z,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_x,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_y,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_z,
	output logic                                degenerate
);

	localparam int PW = ttb_pkg::POS_W;
	localparam int TW = ttb_pkg::TEX_W;
	localparam int EW = ttb_pkg::EDGE_W;
	localparam int UW = ttb_pkg::DUV_W;
	localparam int DW = ttb_pkg::DET_W;
	localparam int NW = ttb_pkg::NUM_W;
	localparam int QW = ttb_pkg::DIVD_W;
	localparam int CW = ttb_pkg::DCNT_W;
	localparam int OW = ttb_pkg::OUT_W;

	logic signed [PW-1:0] px_q [2], py_q [2], pz_q [2];
	logic signed [TW-1:0] tu_q [2], tv_q [2];
	logic signed [EW-1:0] e1_q [3], e2_q [3];
	logic signed [UW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DW-1:0] det_q;
	logic signed [NW-1:0] num_q [6];
	logic signed [OW-1:0] res_q [6];
	logic                 zero_q;

	// divider state
	logic [QW-1:0]  quo_q;
	logic [ttb_pkg::DMAG_W:0] rem_q;
	logic [ttb_pkg::DMAG_W-1:0] dmag_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;

	logic signed [NW-1:0] num_sel;
	logic [NW-1:0]        nmag;
	logic [ttb_pkg::DMAG_W:0] rem_sh, rem_sub;
	logic                 fits;
	logic signed [OW-1:0] q_sat;
	logic [OW-1:0]        q_lo;
	logic                 q_ovf;

	assign num_sel = num_q[cmd.sel];
	assign nmag    = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);

	// restoring division step, one quotient bit per cycle
	assign rem_sh  = {rem_q[ttb_pkg::DMAG_W-1:0], quo_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, dmag_q};
	assign fits    = !rem_sub[ttb_pkg::DMAG_W];

	// saturate the quotient magnitude and apply the sign
	always_comb begin
		q_ovf = |quo_q[QW-1:OW-1];
		q_lo  = {1'b0, quo_q[OW-2:0]};
		if (q_ovf) q_sat = neg_q ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		else       q_sat = neg_q ? OW'(-q_lo) : OW'(q_lo);
	end

	assign sts.det_zero = zero_q;
	assign sts.div_done = (cnt_q == CW'(1));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ttb_pkg::OP_STORE: begin
				px_q[cmd.slot] <= pos_x;
				py_q[cmd.slot] <= pos_y;
				pz_q[cmd.slot] <= pos_z;
				tu_q[cmd.slot] <= tex_u;
				tv_q[cmd.slot] <= tex_v;
			end
			ttb_pkg::OP_DELTA: begin
				e1_q[0] <= EW'(px_q[1]) - EW'(px_q[0]);
				e1_q[1] <= EW'(py_q[1]) - EW'(py_q[0]);
				e1_q[2] <= EW'(pz_q[1]) - EW'(pz_q[0]);
				e2_q[0] <= EW'(pos_x) - EW'(px_q[0]);
				e2_q[1] <= EW'(pos_y) - EW'(py_q[0]);
				e2_q[2] <= EW'(pos_z) - EW'(pz_q[0]);
				du1_q   <= UW'(tu_q[1]) - UW'(tu_q[0]);
				dv1_q   <= UW'(tv_q[1]) - UW'(tv_q[0]);
				du2_q   <= UW'(tex_u) - UW'(tu_q[0]);
				dv2_q   <= UW'(tex_v) - UW'(tv_q[0]);
			end
			ttb_pkg::OP_DET: begin
				det_q  <= DW'(du1_q * dv2_q) - DW'(du2_q * dv1_q);
				zero_q <= DW'(du1_q * dv2_q) == DW'(du2_q * dv1_q);
			end
			ttb_pkg::OP_NUM: begin
				for (int k = 0; k < 3; k++) begin
					num_q[k]   <= NW'(dv2_q * e1_q[k]) - NW'(dv1_q * e2_q[k]);
					num_q[3+k] <= NW'(du1_q * e2_q[k]) - NW'(du2_q * e1_q[k]);
				end
				if (zero_q) begin
					for (int k = 0; k < 6; k++) res_q[k] <= '0;
				end
				degenerate <= zero_q;
			end
			ttb_pkg::OP_DIV_START: begin
				quo_q  <= {nmag, {ttb_pkg::FRAC_BITS{1'b0}}};
				rem_q  <= '0;
				dmag_q <= det_q[DW-1] ? ttb_pkg::DMAG_W'(-det_q) : ttb_pkg::DMAG_W'(det_q);
				neg_q  <= num_sel[NW-1] ^ det_q[DW-1];
				cnt_q  <= CW'(QW);
			end
			ttb_pkg::OP_DIV_STEP: begin
				rem_q <= fits ? rem_sub : rem_sh;
				quo_q <= {quo_q[QW-2:0], fits};
				cnt_q <= cnt_q - CW'(1);
			end
			ttb_pkg::OP_DIV_SAVE: res_q[cmd.sel] <= q_sat;
			ttb_pkg::OP_NONE: ;
			default: ;
		endcase
	end

	assign tangent_x   = res_q[0];
	assign tangent_y   = res_q[1];
	assign tangent_z   = res_q[2];
	assign bitangent_x = res_q[3];
	assign bitangent_y = res_q[4];
	assign bitangent_z = res_q[5];

endmodule

### design/triangle_tangent_basis_core.sv
// Triangle tangent/bitangent unit.
// Input channel (in_valid/in_ready) takes one triangle corner per transaction:
// position pos_x/y/z in signed Q8.16, texture coordinate tex_u/v in Q4.16.
// The first two corners of each triangle are stored and give no result; the
// third starts the computation and yields one result transaction on the
// output channel (out_valid/out_ready): tangent and bitangent in signed
// Q16.16, saturated, and a degenerate flag (zero UV determinant, zero vectors).
// From the third corner: the deltas are registered, then the determinant and
// the numerators, then 6 serial divisions (start, 63 quotient bits through a
// shared restoring divider, save), and then out_valid is raised; a degenerate
// triangle skips the divisions and raises out_valid after the numerators.
// Corners are taken only while the unit is idle, so a new triangle starts only
// once the previous one has finished.
// Results stay on the ports while out_valid is high; corners are refused
// while a result waits, so a stalled receiver stalls the input.
// Reset clears the corner count and the output valid.
module triangle_tangent_basis_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_x,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_y,
	input  logic signed [ttb_pkg::POS_W-1:0]    pos_z,
	input  logic signed [ttb_pkg::TEX_W-1:0]    tex_u,
	input  logic signed [ttb_pkg::TEX_W-1:0]    tex_v,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_x,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_y,
	output logic signed [ttb_pkg::OUT_W-1:0]    tangent_z,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_x,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_y,
	output logic signed [ttb_pkg::OUT_W-1:0]    bitangent_z,
	output logic                                degenerate
);

	ttb_pkg::cmd_t cmd;
	ttb_pkg::sts_t sts;

	ttb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ttb_dpath u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.tangent_x   (tangent_x),
		.tangent_y   (tangent_y),
		.tangent_z   (tangent_z),
		.bitangent_x (bitangent_x),
		.bitangent_y (bitangent_y),
		.bitangent_z (bitangent_z),
		.degenerate  (degenerate)
	);

endmodule
